>>> hdl/ade_pkg.sv
// ----------------------------------------------------------------------------
// ade_pkg
// Types and helpers shared by the data-processing encoder pipeline.
// ----------------------------------------------------------------------------
package ade_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned ConstW = 64;
  localparam int unsigned NumRot = 16;
  localparam int unsigned RotW   = 4;
  localparam int unsigned Op2W   = 12;
  localparam int unsigned InDataW = 96;

  localparam logic [3:0] OpcodeTst = 4'd8;
  localparam logic [3:0] OpcodeTeq = 4'd9;
  localparam logic [3:0] OpcodeCmp = 4'd10;
  localparam logic [3:0] RegPcIdx  = 4'd15;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_RANGE = 2'd1,
    ERR_REG   = 2'd2
  } err_e;

  typedef enum logic [1:0] {
    FORM_IMM = 2'd0,
    FORM_SHC = 2'd1,
    FORM_SHR = 2'd2
  } form_e;

  typedef struct packed {
    logic [3:0] cond;
    logic [3:0] opcode;
    logic       s_bit;
    logic [3:0] reg_n;
    logic [3:0] reg_d;
  } hdr_t;

  typedef struct packed {
    hdr_t              hdr;
    form_e             form;
    logic              imm_fits;
    logic [WordW-1:0]  value;
    logic [NumRot-1:0] hits;
    logic [Op2W-1:0]   reg_op2;
    err_e              reg_err;
  } s1_t;

  typedef struct packed {
    hdr_t            hdr;
    logic            i_bit;
    logic [Op2W-1:0] op2;
    err_e            err;
  } s2_t;

  function automatic logic [WordW-1:0] rotl32(logic [WordW-1:0] x, logic [5:0] n);
    logic [2*WordW-1:0] wide;
    wide = {x, x} << n[4:0];
    return wide[2*WordW-1:WordW];
  endfunction

endpackage

>>> hdl/ade_check.sv
// ----------------------------------------------------------------------------
// ade_check
// First stage: range checks, shift-form operands and rotation hit flags.
// ----------------------------------------------------------------------------
module ade_check (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [1:0]                kind_i,
  input  logic [3:0]                cond_i,
  input  logic [3:0]                opcode_i,
  input  logic [3:0]                reg_n_i,
  input  logic [3:0]                reg_d_i,
  input  logic [3:0]                reg_m_i,
  input  logic [1:0]                shift_type_i,
  input  logic [3:0]                reg_s_i,
  input  logic [ade_pkg::ConstW-1:0] constant_i,
  output logic                      valid_o,
  output ade_pkg::s1_t              data_o
);
  import ade_pkg::*;

  logic valid_q;
  s1_t  data_d, data_q;
  logic [WordW-1:0] rot;

  always_comb begin
    data_d.hdr.cond   = cond_i;
    data_d.hdr.opcode = opcode_i;
    data_d.hdr.s_bit  = (opcode_i == OpcodeTst) || (opcode_i == OpcodeTeq) ||
                        (opcode_i == OpcodeCmp);
    data_d.hdr.reg_n  = reg_n_i;
    data_d.hdr.reg_d  = reg_d_i;
    data_d.value      = constant_i[WordW-1:0];
    data_d.imm_fits   = (constant_i[ConstW-1:WordW] == '0);
    data_d.hits       = '0;
    rot               = '0;
    for (int r = 0; r < NumRot; r++) begin
      rot = rotl32(constant_i[WordW-1:0], 6'(2 * r));
      data_d.hits[r] = (rot[WordW-1:8] == '0);
    end
    if (kind_i == FORM_IMM) begin
      data_d.form = FORM_IMM;
    end else if (kind_i == FORM_SHC) begin
      data_d.form = FORM_SHC;
    end else begin
      data_d.form = FORM_SHR;
    end
    if (data_d.form == FORM_SHC) begin
      data_d.reg_op2 = {constant_i[4:0], shift_type_i, 1'b0, reg_m_i};
      data_d.reg_err = (constant_i[ConstW-1:5] == '0) ? ERR_NONE : ERR_RANGE;
    end else begin
      data_d.reg_op2 = {reg_s_i, 1'b0, shift_type_i, 1'b1, reg_m_i};
      data_d.reg_err = (reg_s_i == RegPcIdx) ? ERR_REG : ERR_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> hdl/ade_rot_sel.sv
// ----------------------------------------------------------------------------
// ade_rot_sel
// Second stage: picks the smallest fitting rotation and forms operand 2.
// ----------------------------------------------------------------------------
module ade_rot_sel (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         valid_i,
  input  ade_pkg::s1_t data_i,
  output logic         valid_o,
  output ade_pkg::s2_t data_o
);
  import ade_pkg::*;

  logic            valid_q;
  s2_t             data_d, data_q;
  logic [RotW-1:0] rot_sel;
  logic [WordW-1:0] rotated;

  always_comb begin
    rot_sel = '0;
    for (int r = NumRot - 1; r >= 0; r--) begin
      if (data_i.hits[r]) begin
        rot_sel = RotW'(r);
      end
    end
    rotated     = rotl32(data_i.value, {1'b0, rot_sel, 1'b0});
    data_d.hdr  = data_i.hdr;
    if (data_i.form == FORM_IMM) begin
      data_d.i_bit = 1'b1;
      data_d.op2   = {rot_sel, rotated[7:0]};
      data_d.err   = (data_i.imm_fits && (data_i.hits != '0)) ? ERR_NONE : ERR_RANGE;
    end else begin
      data_d.i_bit = 1'b0;
      data_d.op2   = data_i.reg_op2;
      data_d.err   = data_i.reg_err;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> hdl/ade_pack.sv
// ----------------------------------------------------------------------------
// ade_pack
// Third stage: assembles the instruction word and holds the output register.
// ----------------------------------------------------------------------------
module ade_pack (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  ade_pkg::s2_t             data_i,
  output logic                     valid_o,
  output logic [ade_pkg::WordW-1:0] word_o,
  output ade_pkg::err_e            error_o
);
  import ade_pkg::*;

  logic             valid_q;
  logic [WordW-1:0] word_d, word_q;
  err_e             error_q;

  always_comb begin
    if (data_i.err == ERR_NONE) begin
      word_d = {data_i.hdr.cond, 2'b00, data_i.i_bit, data_i.hdr.opcode, data_i.hdr.s_bit,
                data_i.hdr.reg_n, data_i.hdr.reg_d, data_i.op2};
    end else begin
      word_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      word_q  <= word_d;
      error_q <= data_i.err;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;
  assign error_o = error_q;

endmodule

>>> hdl/arm_data_processing_encoder.sv
// ----------------------------------------------------------------------------
// arm_data_processing_encoder
// Encodes one ARM data-processing instruction word per input word.
// ----------------------------------------------------------------------------
// The encoder takes one word per clock while the output does not stall,
// through a three-stage pipeline (checks and rotation flags, rotation pick,
// word assembly with the output register), and each result passes through
// the stage registers in order before it appears on the output. Words stay
// in order, and a stall on the output only holds the stages that are full,
// so bubbles are squeezed out. Errors give a zero word with the code in tuser.
module arm_data_processing_encoder (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // cond, opcode, reg_n, reg_d, reg_m, shift_type, reg_s, constant, zero pad
  input  logic [ade_pkg::InDataW-1:0] s_axis_tdata,
  // kind
  input  logic [1:0]                  s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // word
  output logic [ade_pkg::WordW-1:0]   m_axis_tdata,
  // error
  output logic [1:0]                  m_axis_tuser
);
  import ade_pkg::*;

  logic en1, en2, en3;
  logic v1, v2;
  s1_t  d1;
  s2_t  d2;
  err_e error;

  assign en3           = !m_axis_tvalid || m_axis_tready;
  assign en2           = !v2 || en3;
  assign en1           = !v1 || en2;
  assign s_axis_tready = en1;

  ade_check u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en1),
    .valid_i      (s_axis_tvalid),
    .kind_i       (s_axis_tuser),
    .cond_i       (s_axis_tdata[3:0]),
    .opcode_i     (s_axis_tdata[7:4]),
    .reg_n_i      (s_axis_tdata[11:8]),
    .reg_d_i      (s_axis_tdata[15:12]),
    .reg_m_i      (s_axis_tdata[19:16]),
    .shift_type_i (s_axis_tdata[21:20]),
    .reg_s_i      (s_axis_tdata[25:22]),
    .constant_i   (s_axis_tdata[89:26]),
    .valid_o      (v1),
    .data_o       (d1)
  );

  ade_rot_sel u_rot_sel (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en2),
    .valid_i (v1),
    .data_i  (d1),
    .valid_o (v2),
    .data_o  (d2)
  );

  ade_pack u_pack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en3),
    .valid_i (v2),
    .data_i  (d2),
    .valid_o (m_axis_tvalid),
    .word_o  (m_axis_tdata),
    .error_o (error)
  );

  assign m_axis_tuser = error;

endmodule
